>>> src/b64d_pkg.sv
// Shared types, constants and the character decode function of the base64url decoder.
`timescale 1ns / 1ps
package b64d_pkg;

  // Depth of the request queue between the front and the back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Bit 6 of a decoded character marks a character outside the alphabet.
  localparam logic [6:0] SEXTET_INVALID = 7'h40;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_CHAR = 2'd1,
    ST_LONE     = 2'd2,
    ST_SPARE    = 2'd3
  } status_t;

  // One queued request: up to three bytes packed high first. A byte count of
  // zero means a single status-only result.
  typedef struct packed {
    logic [23:0] chunk;
    logic [1:0]  count;
    status_t     status;
    logic        eot;
  } job_t;

  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] v;
    v = SEXTET_INVALID;
    if (c inside {[8'h41:8'h5A]}) begin
      v = {1'b0, 6'(c - 8'h41)};
    end else if (c inside {[8'h61:8'h7A]}) begin
      v = {1'b0, 6'(c - 8'h47)};
    end else if (c inside {[8'h30:8'h39]}) begin
      v = {1'b0, 6'(c + 8'h04)};
    end else if (c == 8'h2D) begin
      v = 7'd62;
    end else if (c == 8'h5F) begin
      v = 7'd63;
    end
    return v;
  endfunction

endpackage

>>> src/b64d_front.sv
// Front end: character classification, group assembly and request generation.
`timescale 1ns / 1ps
module b64d_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           accept,
  input  logic [7:0]     character,
  input  logic           end_of_text,
  output logic           push,
  output b64d_pkg::job_t job
);

  logic [17:0] held_r, held_nxt;
  logic [1:0]  fill_r, fill_nxt;
  logic        sticky_r, sticky_nxt;

  logic [6:0]  dec;
  logic [5:0]  v;
  logic [23:0] chunk;
  logic        spare_bad;

  assign dec = b64d_pkg::sextet_of(character);
  assign v   = dec[5:0];

  always_comb begin
    case (fill_r)
      2'd0:    chunk = {v, 18'd0};
      2'd1:    chunk = {held_r[5:0], v, 12'd0};
      2'd2:    chunk = {held_r[11:0], v, 6'd0};
      default: chunk = {held_r, v};
    endcase
  end

  assign spare_bad = ((fill_r == 2'd1) && (v[3:0] != 4'd0)) ||
                     ((fill_r == 2'd2) && (v[1:0] != 2'd0));

  always_comb begin
    held_nxt     = held_r;
    fill_nxt     = fill_r;
    sticky_nxt   = sticky_r;
    push         = 1'b0;
    job.chunk    = chunk;
    job.count    = 2'd0;
    job.status   = b64d_pkg::ST_OK;
    job.eot      = 1'b0;
    if (accept) begin
      if (sticky_r || dec[6]) begin
        // Once a bad character is seen, only the closing status comes out.
        held_nxt   = 18'd0;
        fill_nxt   = 2'd0;
        sticky_nxt = !end_of_text;
        if (end_of_text) begin
          push       = 1'b1;
          job.status = b64d_pkg::ST_BAD_CHAR;
          job.eot    = 1'b1;
        end
      end else if (!end_of_text) begin
        if (fill_r == 2'd3) begin
          push      = 1'b1;
          job.count = 2'd3;
          held_nxt  = 18'd0;
          fill_nxt  = 2'd0;
        end else begin
          held_nxt = {held_r[11:0], v};
          fill_nxt = fill_r + 2'd1;
        end
      end else begin
        push     = 1'b1;
        job.eot  = 1'b1;
        held_nxt = 18'd0;
        fill_nxt = 2'd0;
        if (fill_r == 2'd0) begin
          job.status = b64d_pkg::ST_LONE;
        end else if (spare_bad) begin
          job.status = b64d_pkg::ST_SPARE;
        end else begin
          job.count = fill_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r   <= 18'd0;
      fill_r   <= 2'd0;
      sticky_r <= 1'b0;
    end else begin
      held_r   <= held_nxt;
      fill_r   <= fill_nxt;
      sticky_r <= sticky_nxt;
    end
  end

  a_sticky_empty: assert property (@(posedge clk) disable iff (!rst_n)
    sticky_r |-> (fill_r == 2'd0 && held_r == 18'd0))
    else $error("group not cleared while in error");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && end_of_text) |=> (fill_r == 2'd0 && !sticky_r))
    else $error("state not reset after token end");

  a_status_only: assert property (@(posedge clk) disable iff (!rst_n)
    (push && job.status != b64d_pkg::ST_OK) |-> (job.count == 2'd0 && job.eot))
    else $error("error request carries bytes");

endmodule

>>> src/b64d_queue.sv
// Short request queue that decouples the front end from the output serializer.
`timescale 1ns / 1ps
module b64d_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  b64d_pkg::job_t push_job,
  input  logic           pop,
  output logic           full,
  output logic           head_valid,
  output b64d_pkg::job_t head_job
);

  b64d_pkg::job_t                slot_r [b64d_pkg::QDEPTH];
  logic [b64d_pkg::QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [b64d_pkg::QCNT_W-1:0]   cnt_r;

  assign full       = (cnt_r == b64d_pkg::QCNT_W'(b64d_pkg::QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_job   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= b64d_pkg::QCNT_W'(b64d_pkg::QDEPTH))
    else $error("queue count out of range");

endmodule

>>> src/b64d_back.sv
// Back end: one result per unstalled cycle from queued requests via an output register.
`timescale 1ns / 1ps
module b64d_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           head_valid,
  input  b64d_pkg::job_t head_job,
  output logic           pop,
  output logic           out_vld,
  input  logic           out_stall,
  output logic [7:0]     out_data_byte,
  output logic           out_byte_valid,
  output logic [1:0]     out_status,
  output logic           out_end_of_token
);

  logic [1:0] k_r, k_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic       bval_r;
  logic [1:0] status_r;
  logic       eot_r;

  logic       load;
  logic       is_last;
  logic [7:0] sel_byte;

  assign load    = head_valid && (!valid_r || !out_stall);
  assign is_last = (head_job.count == 2'd0) ? 1'b1 : (k_r == head_job.count - 2'd1);
  assign pop     = load && is_last;

  always_comb begin
    case (k_r)
      2'd0:    sel_byte = head_job.chunk[23:16];
      2'd1:    sel_byte = head_job.chunk[15:8];
      default: sel_byte = head_job.chunk[7:0];
    endcase
  end

  always_comb begin
    k_nxt     = k_r;
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
      k_nxt     = is_last ? 2'd0 : k_r + 2'd1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r     <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      k_r     <= k_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bval_r   <= (head_job.count != 2'd0);
      byte_r   <= (head_job.count != 2'd0) ? sel_byte : 8'd0;
      status_r <= is_last ? head_job.status : b64d_pkg::ST_OK;
      eot_r    <= is_last && head_job.eot;
    end
  end

  assign out_vld          = valid_r;
  assign out_data_byte    = byte_r;
  assign out_byte_valid   = bval_r;
  assign out_status       = status_r;
  assign out_end_of_token = eot_r;

endmodule

>>> src/base64url_strict_decoder_unit.sv
// Top level of the unpadded base64url decoder with strict spare-bit checking.
`timescale 1ns / 1ps
// The decoder takes one character of a base64url token per request and
// accepts a new character every cycle while its request queue has room.
// Characters are classified and gathered into groups of four in the front
// end; every full group, and the closing group or status at the token end,
// becomes one queued request. The back end turns each request into one to
// three results, one result per cycle while the output is not stalled,
// through a registered output stage, so four characters (three bytes)
// sustain one character per cycle. A completed group releases three results
// at once and a token end at most three; the four-entry queue absorbs these
// bursts, and the input stalls only when the queue is full. Each request is
// queued, and its first result then passes through the output register.
// Bytes stream out as soon as their group completes, so bytes
// of a token that later proves bad have already been delivered; the final
// result of every token carries end_of_token and its status (ok, bad
// character, lone trailing character, or nonzero spare bits), and all error
// results are status-only with byte_valid low.
module base64url_strict_decoder_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_character,
  input  logic       in_end_of_text,
  output logic       out_vld,
  input  logic       out_stall,
  output logic [7:0] out_data_byte,
  output logic       out_byte_valid,
  output logic [1:0] out_status,
  output logic       out_end_of_token
);

  logic           accept;
  logic           push;
  logic           pop;
  logic           q_full;
  logic           head_valid;
  b64d_pkg::job_t push_job;
  b64d_pkg::job_t head_job;

  // The front end can always push at most one request per character, so a
  // free queue slot is all it needs to take the next character.
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  b64d_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .character   (in_character),
    .end_of_text (in_end_of_text),
    .push        (push),
    .job         (push_job)
  );

  b64d_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  b64d_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_valid       (head_valid),
    .head_job         (head_job),
    .pop              (pop),
    .out_vld          (out_vld),
    .out_stall        (out_stall),
    .out_data_byte    (out_data_byte),
    .out_byte_valid   (out_byte_valid),
    .out_status       (out_status),
    .out_end_of_token (out_end_of_token)
  );

endmodule

>>> verif/tb_base64url_strict_decoder_unit.sv
// Self-checking testbench for the unpadded base64url decoder unit.
`timescale 1ns / 1ps
// The testbench sends base64url tokens one character per request and checks
// every decoded byte and every end-of-token status against its own model of
// the decoder. A short table of directed characters comes first. It covers a
// lone trailing character, bad characters, nonzero spare bits in closing
// groups of two and three, and the one-, two- and three-byte closing groups.
// Random tokens follow in three phases of idling. Most of them are well
// formed with random content, so that the decoder walks through every group
// position. The rest have a bad character inside, random lengths with
// arbitrary spare bits, or are pure noise bytes.
module tb_base64url_strict_decoder_unit;

  // One decoded result as the decoder presents it on the output channel.
  typedef struct packed {
    logic [7:0]         data;
    logic               has_byte;
    b64d_pkg::status_t  status;
    logic               eot;
  } decoded_t;

  // One row of the directed table. When the row closes a token with an
  // error, its status-only result is typed in; otherwise the model decides.
  typedef struct packed {
    logic [7:0]         chr;
    logic               eot;
    logic               typed;
    b64d_pkg::status_t  status;
  } char_row_t;

  localparam int NUM_ROWS    = 26;
  localparam int TOTAL_ITEMS = 470;

  localparam char_row_t CHAR_ROWS [NUM_ROWS] = '{
    '{"A",   1'b1, 1'b1, b64d_pkg::ST_LONE},      // a lone character right after reset
    '{8'hFF, 1'b1, 1'b1, b64d_pkg::ST_BAD_CHAR},  // bad and lone at once: bad wins
    '{"_",   1'b0, 1'b0, b64d_pkg::ST_OK},        // full group of all-ones sextets
    '{"_",   1'b0, 1'b0, b64d_pkg::ST_OK},
    '{"_",   1'b0, 1'b0, b64d_pkg::ST_OK},
    '{"_",   1'b0, 1'b0, b64d_pkg::ST_OK},
    '{"-",   1'b0, 1'b0, b64d_pkg::ST_OK},        // closing group of two, one byte
    '{"w",   1'b1, 1'b0, b64d_pkg::ST_OK},
    '{"A",   1'b0, 1'b0, b64d_pkg::ST_OK},        // spare bits set in a group of two
    '{"B",   1'b1, 1'b1, b64d_pkg::ST_SPARE},
    '{"A",   1'b0, 1'b0, b64d_pkg::ST_OK},        // spare bits set in a group of three
    '{"A",   1'b0, 1'b0, b64d_pkg::ST_OK},
    '{"B",   1'b1, 1'b1, b64d_pkg::ST_SPARE},
    '{"z",   1'b0, 1'b0, b64d_pkg::ST_OK},        // closing group of three, two bytes
    '{"z",   1'b0, 1'b0, b64d_pkg::ST_OK},
    '{"8",   1'b1, 1'b0, b64d_pkg::ST_OK},
    '{"a",   1'b0, 1'b0, b64d_pkg::ST_OK},        // bytes leave before the bad character
    '{"b",   1'b0, 1'b0, b64d_pkg::ST_OK},
    '{"c",   1'b0, 1'b0, b64d_pkg::ST_OK},
    '{"d",   1'b0, 1'b0, b64d_pkg::ST_OK},
    '{8'h00, 1'b0, 1'b0, b64d_pkg::ST_OK},
    '{"Q",   1'b1, 1'b1, b64d_pkg::ST_BAD_CHAR},
    '{"z",   1'b0, 1'b0, b64d_pkg::ST_OK},        // token ends on a full group
    '{"Z",   1'b0, 1'b0, b64d_pkg::ST_OK},
    '{"0",   1'b0, 1'b0, b64d_pkg::ST_OK},
    '{"9",   1'b1, 1'b0, b64d_pkg::ST_OK}
  };

  logic       clk;
  logic       rst_n          = 1'b0;
  logic       in_valid       = 1'b0;
  logic       in_stall;
  logic [7:0] in_character   = 8'h00;
  logic       in_end_of_text = 1'b0;
  logic       out_vld;
  logic       out_stall      = 1'b1;
  logic [7:0] out_data_byte;
  logic       out_byte_valid;
  logic [1:0] out_status;
  logic       out_end_of_token;

  // Idling rates in percent, changed between the phases of the random part.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // The decoder's state as the checker models it.
  logic [17:0] dec_held;
  logic [1:0]  dec_fill;
  logic        dec_bad;

  // Results the decoder owes, oldest first.
  decoded_t decoded_fifo [$];
  decoded_t next_decoded;

  int errors       = 0;
  int chars_sent   = 0;
  int tokens_sent  = 0;
  int results_seen = 0;
  int status_seen [4];

  base64url_strict_decoder_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_character     (in_character),
    .in_end_of_text   (in_end_of_text),
    .out_vld          (out_vld),
    .out_stall        (out_stall),
    .out_data_byte    (out_data_byte),
    .out_byte_valid   (out_byte_valid),
    .out_status       (out_status),
    .out_end_of_token (out_end_of_token)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Six-bit value of a character, with bit 6 set for anything outside the
  // alphabet.
  function automatic logic [6:0] sextet_value(input logic [7:0] c);
    logic [6:0] v;
    v = b64d_pkg::SEXTET_INVALID;
    if (c >= "A" && c <= "Z") begin
      v = {1'b0, 6'(c - "A")};
    end else if (c >= "a" && c <= "z") begin
      v = {1'b0, 6'(c - "a" + 8'd26)};
    end else if (c >= "0" && c <= "9") begin
      v = {1'b0, 6'(c - "0" + 8'd52)};
    end else if (c == "-") begin
      v = 7'd62;
    end else if (c == "_") begin
      v = 7'd63;
    end
    return v;
  endfunction

  // Character that encodes a six-bit value.
  function automatic logic [7:0] alphabet_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = "A" + 8'(v);
    end else if (v < 6'd52) begin
      c = "a" + 8'(v - 6'd26);
    end else if (v < 6'd62) begin
      c = "0" + 8'(v - 6'd52);
    end else if (v == 6'd62) begin
      c = "-";
    end else begin
      c = "_";
    end
    return c;
  endfunction

  // Advances the modeled decoder by one character. Its results are queued
  // only when enqueue is set; the directed rows with a typed-in status keep
  // the model in step but supply their result themselves.
  task automatic decode_char(input logic [7:0] c, input logic e, input bit enqueue);
    logic [6:0]  v;
    logic [2:0]  total;
    logic [23:0] chunk;
    int          nbytes;
    decoded_t    r [$];
    v = sextet_value(c);
    if (!dec_bad && v[6]) begin
      dec_bad  = 1'b1;
      dec_held = '0;
      dec_fill = '0;
    end
    if (dec_bad) begin
      // Nothing leaves until the token end, which reports the bad character.
      if (e) begin
        r.push_back('{8'h00, 1'b0, b64d_pkg::ST_BAD_CHAR, 1'b1});
      end
    end else begin
      total = 3'(dec_fill) + 3'd1;
      chunk = {dec_held, v[5:0]} << (6 * (4 - total));
      if (!e) begin
        if (total < 3'd4) begin
          dec_held = {dec_held[11:0], v[5:0]};
          dec_fill = total[1:0];
        end else begin
          for (int i = 0; i < 3; i++) begin
            r.push_back('{chunk[23 - 8 * i -: 8], 1'b1, b64d_pkg::ST_OK, 1'b0});
          end
          dec_held = '0;
          dec_fill = '0;
        end
      end else if (total == 3'd1) begin
        r.push_back('{8'h00, 1'b0, b64d_pkg::ST_LONE, 1'b1});
      end else if ((total == 3'd2 && v[3:0] != 4'd0) ||
                   (total == 3'd3 && v[1:0] != 2'd0)) begin
        r.push_back('{8'h00, 1'b0, b64d_pkg::ST_SPARE, 1'b1});
      end else begin
        // The closing group: the last byte carries the token end.
        nbytes = int'(total) - 1;
        for (int i = 0; i < nbytes; i++) begin
          r.push_back('{chunk[23 - 8 * i -: 8], 1'b1, b64d_pkg::ST_OK, (i == nbytes - 1)});
        end
      end
    end
    // Every token end returns the decoder to its reset state.
    if (e) begin
      dec_bad  = 1'b0;
      dec_held = '0;
      dec_fill = '0;
    end
    if (enqueue) begin
      foreach (r[i]) decoded_fifo.push_back(r[i]);
    end
  endtask

  // Offers one character, after a random number of idle cycles, and holds it
  // until the decoder takes the request. The stall is sampled at the falling
  // edge, where it is settled for the rising edge that follows. Valid is left
  // high after acceptance so that back-to-back requests never lower it.
  task automatic send_char(input logic [7:0] c, input logic e, input bit typed,
                           input b64d_pkg::status_t typed_status);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_character   <= c;
    in_end_of_text <= e;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    // The request is taken at the next rising edge.
    decode_char(c, e, !typed);
    if (typed) begin
      decoded_fifo.push_back('{8'h00, 1'b0, typed_status, 1'b1});
    end
    chars_sent++;
    if (e) tokens_sent++;
    @(posedge clk);
  endtask

  // Sends one random token. Most tokens are well formed with random content;
  // the rest are random lengths with arbitrary spare bits, well-formed bodies
  // with one bad character, or plain noise bytes.
  task automatic send_random_token();
    logic [7:0] token [$];
    logic [6:0] v;
    logic [7:0] c;
    int         kind;
    int         groups;
    int         tail;
    int         len;
    kind = $urandom_range(0, 9);
    if (kind <= 5) begin
      groups = $urandom_range(0, 3);
      tail   = $urandom_range(0, 2);
      tail   = (tail == 0) ? 0 : tail + 1;
      if (groups == 0 && tail == 0) tail = 2;
      repeat (4 * groups + (tail > 0 ? tail - 1 : 0)) begin
        token.push_back(alphabet_char(6'($urandom_range(0, 63))));
      end
      // The closing character of a short group keeps its spare bits clear.
      if (tail == 2) begin
        token.push_back(alphabet_char({2'($urandom_range(0, 3)), 4'b0000}));
      end else if (tail == 3) begin
        token.push_back(alphabet_char({4'($urandom_range(0, 15)), 2'b00}));
      end
    end else if (kind <= 7) begin
      len = $urandom_range(1, 10);
      repeat (len) token.push_back(alphabet_char(6'($urandom_range(0, 63))));
    end else if (kind == 8) begin
      len = $urandom_range(1, 9);
      repeat (len) token.push_back(alphabet_char(6'($urandom_range(0, 63))));
      do begin
        c = 8'($urandom_range(0, 255));
        v = sextet_value(c);
      end while (!v[6]);
      token[$urandom_range(0, len - 1)] = c;
    end else begin
      len = $urandom_range(1, 6);
      repeat (len) token.push_back(8'($urandom_range(0, 255)));
    end
    foreach (token[i]) begin
      send_char(token[i], (i == token.size() - 1), 1'b0, b64d_pkg::ST_OK);
    end
  endtask

  task automatic check_field(input string field, input int expected, input int actual);
    if (expected != actual) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, expected, actual);
    end
  endtask

  // The receiver stalls at random; the stall changes only at rising edges.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // A result is taken at the rising edge after a falling edge that sees valid
  // high and stall low; both are settled by then.
  always @(negedge clk) begin
    if (rst_n && out_vld && !out_stall) begin
      results_seen++;
      if (decoded_fifo.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got byte %0h status %0d", $time,
                 out_data_byte, out_status);
      end else begin
        next_decoded = decoded_fifo.pop_front();
        check_field("data_byte", next_decoded.data, out_data_byte);
        check_field("byte_valid", next_decoded.has_byte, out_byte_valid);
        check_field("status", next_decoded.status, out_status);
        check_field("end_of_token", next_decoded.eot, out_end_of_token);
        if (out_end_of_token) status_seen[out_status]++;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("%0t: run timed out with %0d results outstanding", $time,
             decoded_fifo.size());
    $display("** base64url_strict_decoder_unit: FAILED **");
    $finish;
  end

  initial begin
    dec_held = '0;
    dec_fill = '0;
    dec_bad  = 1'b0;
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table, with the receiver always ready.
    recv_stall_pct = 0;
    foreach (CHAR_ROWS[i]) begin
      send_char(CHAR_ROWS[i].chr, CHAR_ROWS[i].eot, CHAR_ROWS[i].typed,
                CHAR_ROWS[i].status);
    end

    // Random tokens in three phases: a slow receiver, then a slow sender,
    // then both at full speed.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct  = (phase == 0) ? 33 : (phase == 1) ? 80 : 0;
      recv_stall_pct = (phase == 0) ? 80 : (phase == 1) ? 33 : 0;
      while (chars_sent < NUM_ROWS + ((TOTAL_ITEMS - NUM_ROWS) * (phase + 1)) / 3) begin
        send_random_token();
      end
    end
    in_valid <= 1'b0;

    while (decoded_fifo.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("Sent %0d characters in %0d tokens; checked %0d results.",
             chars_sent, tokens_sent, results_seen);
    $display("Token ends: %0d ok, %0d bad character, %0d lone character, %0d spare bits.",
             status_seen[b64d_pkg::ST_OK], status_seen[b64d_pkg::ST_BAD_CHAR],
             status_seen[b64d_pkg::ST_LONE], status_seen[b64d_pkg::ST_SPARE]);
    if (errors == 0) begin
      $display("** base64url_strict_decoder_unit: PASSED **");
    end else begin
      $display("** base64url_strict_decoder_unit: FAILED **");
    end
    $finish;
  end

endmodule
